@@ rtl/core/pmpc_pkg.sv @@
// Shared types and constants for the PS/2 wheel-mouse packet cursor block.
// Holds the packet and result layouts and the register indexes.
// No dependencies.
package pmpc_pkg;

  // Cursor coordinate width, set by the 12-bit cursor and screen fields.
  localparam int COORD_BITS = 12;

  // Default warm-up length in bytes before alignment checks start.
  localparam int WARMUP_BYTES_DEF = 4;

  // Depth of the packet queue between the framer and the cursor unit.
  localparam int QUEUE_DEPTH = 2;

  // Reset values of the screen size registers.
  localparam logic [COORD_BITS-1:0] SCREEN_WIDTH_RST  = COORD_BITS'(1024);
  localparam logic [COORD_BITS-1:0] SCREEN_HEIGHT_RST = COORD_BITS'(768);

  // Configuration register indexes.
  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  // One framed four-byte packet, byte 0 in the lowest bits.
  typedef struct packed {
    logic [7:0] byte3;
    logic [7:0] byte2;
    logic [7:0] byte1;
    logic [7:0] byte0;
  } pkt_t;

  // Decoded result as it sits on the output data bus, last field lowest.
  typedef struct packed {
    logic [2:0]            pad;
    logic [COORD_BITS-1:0] cursor_y;
    logic [COORD_BITS-1:0] cursor_x;
    logic                  middle_button;
    logic                  right_button;
    logic                  left_button;
    logic signed [7:0]     delta_wheel;
    logic signed [8:0]     delta_y;
    logic signed [8:0]     delta_x;
  } result_t;

endpackage

@@ rtl/core/ps2_wheel_mouse_packet_cursor_top.sv @@
// Top level of the PS/2 wheel-mouse packet decoder with clamped cursor.
// Connects the byte framer, the packet queue and the cursor unit.
// Depends on pmpc_pkg, pmpc_front, pmpc_queue and pmpc_back.
//
// Usage: received mouse bytes enter on the s_ stream, one per accepted
// transfer. s_tready drops only while the two-entry packet queue is full.
// After a warm-up of WARMUP_BYTES + 1 bytes the framer drops bytes without
// the always-one header bit until it finds packet alignment; from then on
// every fourth byte completes a packet. A completed packet is queued at the
// edge its last byte is accepted; the cursor unit then moves it from the
// queue into the output register, which raises m_tvalid and carries the
// deltas, buttons and new cursor.
// The cursor unit takes one packet per cycle, so up to one byte per cycle
// is sustained while m_tready stays high. When the receiver stalls, the
// result waits in the output register and the queue absorbs two more
// packets before s_tready falls. Reset clears the buffer, alignment,
// warm-up count and cursor, and loads the screen size registers with
// 1024 by 768. Screen sizes are written through cfg_we/cfg_index/cfg_data.
module ps2_wheel_mouse_packet_cursor_top
  import pmpc_pkg::*;
#(
  parameter int WARMUP_BYTES = WARMUP_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Received byte stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // rx_byte[7:0]
  // Decoded packet stream.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [55:0]           m_tdata,   // delta_x[8:0], delta_y[17:9],
                                           // delta_wheel[25:18], left_button[26],
                                           // right_button[27], middle_button[28],
                                           // cursor_x[40:29], cursor_y[52:41], zeros
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data
);

  logic    accept;
  logic    push;
  pkt_t    push_pkt;
  logic    full;
  logic    head_valid;
  pkt_t    head_pkt;
  logic    pop;
  result_t out_data;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = out_data;

  // Byte framing and alignment.
  pmpc_front #(
    .WARMUP_BYTES (WARMUP_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_byte  (s_tdata),
    .push     (push),
    .push_pkt (push_pkt)
  );

  // Packet queue.
  pmpc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_pkt   (push_pkt),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_pkt   (head_pkt)
  );

  // Decode and cursor update.
  pmpc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head_pkt   (head_pkt),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (out_data)
  );

endmodule

@@ rtl/core/pmpc_front.sv @@
// Byte framer: stores received bytes in the packet buffer, finds packet
// alignment and hands complete synced packets to the queue.
// Depends on pmpc_pkg.
module pmpc_front
  import pmpc_pkg::*;
#(
  parameter int WARMUP_BYTES = WARMUP_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       push,
  output pkt_t       push_pkt
);

  localparam int WarmW = $clog2(WARMUP_BYTES + 2);
  localparam logic [WarmW-1:0] WarmEnd = WarmW'(WARMUP_BYTES + 1);

  logic [7:0]       pkt [4];
  logic [1:0]       slot;
  logic [1:0]       slot_next;
  logic             sync;
  logic             sync_next;
  logic [WarmW-1:0] warm_cnt;
  logic             warm_done;
  logic             drop;

  assign warm_done = (warm_cnt == WarmEnd);

  // Alignment search: drop bytes without the always-one bit, and declare
  // sync on a header byte in slot 0 with no header bit in the other slots.
  always_comb begin
    drop      = !sync && warm_done && !rx_byte[3];
    sync_next = sync;
    if (!sync && warm_done && rx_byte[3] && slot == 2'd0 &&
        !pkt[1][3] && !pkt[2][3] && !pkt[3][3]) begin
      sync_next = 1'b1;
    end
    if (drop) begin
      slot_next = 2'd0;
    end else begin
      slot_next = slot + 2'd1;
    end
  end

  // A packet leaves when the last slot is filled while synced.
  assign push = accept && sync && (slot == 2'd3);
  assign push_pkt = '{byte3: rx_byte, byte2: pkt[2], byte1: pkt[1], byte0: pkt[0]};

  // Framing state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        pkt[i] <= 8'd0;
      end
      slot     <= 2'd0;
      sync     <= 1'b0;
      warm_cnt <= '0;
    end else if (accept) begin
      pkt[slot] <= rx_byte;
      slot      <= slot_next;
      sync      <= sync_next;
      if (!warm_done) begin
        warm_cnt <= warm_cnt + WarmW'(1);
      end
    end
  end

  // Packets only leave once aligned.
  assert property (@(posedge clk) disable iff (rst) push |-> sync)
    else $error("packet pushed while not synced");

  // Sync is kept until reset.
  assert property (@(posedge clk) disable iff (rst) sync |=> sync)
    else $error("sync lost without reset");

  // A completed packet returns the slot pointer to the start.
  assert property (@(posedge clk) disable iff (rst) push |=> slot == 2'd0)
    else $error("slot pointer not rewound after packet");

  // The warm-up counter saturates.
  assert property (@(posedge clk) disable iff (rst) warm_cnt <= WarmEnd)
    else $error("warm-up counter ran past its end");

endmodule

@@ rtl/core/pmpc_queue.sv @@
// Short packet queue between the framer and the cursor unit.
// Depends on pmpc_pkg.
module pmpc_queue
  import pmpc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  pkt_t push_pkt,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output pkt_t head_pkt
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

  pkt_t            entry [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == CntFull);
  assign head_valid = (count != '0);
  assign head_pkt   = entry[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_pkt;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

  // The fill count never passes the depth.
  assert property (@(posedge clk) disable iff (rst) count <= CntFull)
    else $error("queue count overflow");

  // A push into a full queue would lose a packet.
  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");

  // An empty queue with no push stays empty.
  assert property (@(posedge clk) disable iff (rst)
    (count == '0) && !push |=> count == '0)
    else $error("queue filled without a push");

endmodule

@@ rtl/core/pmpc_back.sv @@
// Cursor unit: decodes queued packets, moves and clamps the cursor, and
// holds the result in the output register. Also holds the screen registers.
// Depends on pmpc_pkg.
module pmpc_back
  import pmpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data,
  input  logic                  head_valid,
  input  pkt_t                  head_pkt,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output result_t               out_data
);

  localparam int PosW = COORD_BITS + 2;
  localparam logic [COORD_BITS-1:0] Margin = COORD_BITS'(5);

  logic [COORD_BITS-1:0] screen_width;
  logic [COORD_BITS-1:0] screen_height;
  logic [COORD_BITS-1:0] col;
  logic [COORD_BITS-1:0] row;
  logic [COORD_BITS-1:0] col_next;
  logic [COORD_BITS-1:0] row_next;
  logic [COORD_BITS-1:0] lim_x;
  logic [COORD_BITS-1:0] lim_y;
  logic signed [8:0]     dx;
  logic signed [8:0]     dy;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;

  // Screen size registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Limits: size minus five, floored at zero. A 12-bit size always leaves
  // the limit inside the cursor range.
  assign lim_x = (screen_width  < Margin) ? '0 : screen_width  - Margin;
  assign lim_y = (screen_height < Margin) ? '0 : screen_height - Margin;

  // Deltas carry their ninth bit from the header byte.
  assign dx = {head_pkt.byte0[4], head_pkt.byte1};
  assign dy = {head_pkt.byte0[5], head_pkt.byte2};

  // X adds the delta, Y subtracts it (screen rows grow downward).
  assign pos_x = $signed({2'b00, col}) + PosW'(dx);
  assign pos_y = $signed({2'b00, row}) - PosW'(dy);

  // Clamp both axes to zero and the limit.
  always_comb begin
    if (pos_x[PosW-1]) begin
      col_next = '0;
    end else if (pos_x[PosW-2:0] > {1'b0, lim_x}) begin
      col_next = lim_x;
    end else begin
      col_next = pos_x[COORD_BITS-1:0];
    end
    if (pos_y[PosW-1]) begin
      row_next = '0;
    end else if (pos_y[PosW-2:0] > {1'b0, lim_y}) begin
      row_next = lim_y;
    end else begin
      row_next = pos_y[COORD_BITS-1:0];
    end
  end

  // Take the next packet when the output register is free or draining.
  assign pop = head_valid && (!out_valid || out_ready);

  // Cursor position and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        col       <= col_next;
        row       <= row_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (pop) begin
      out_data.pad           <= '0;
      out_data.cursor_y      <= row_next;
      out_data.cursor_x      <= col_next;
      out_data.middle_button <= head_pkt.byte0[2];
      out_data.right_button  <= head_pkt.byte0[1];
      out_data.left_button   <= head_pkt.byte0[0];
      out_data.delta_wheel   <= head_pkt.byte3;
      out_data.delta_y       <= dy;
      out_data.delta_x       <= dx;
    end
  end

  // The cursor only moves when a packet is taken.
  assert property (@(posedge clk) disable iff (rst)
    !pop |=> $stable(col) && $stable(row))
    else $error("cursor moved without a packet");

  // The cursor never passes the column limit.
  assert property (@(posedge clk) disable iff (rst) pop |-> col_next <= lim_x)
    else $error("cursor column beyond limit");

  // The cursor never passes the row limit.
  assert property (@(posedge clk) disable iff (rst) pop |-> row_next <= lim_y)
    else $error("cursor row beyond limit");

endmodule

@@ tb/pmpc_packet_checker.sv @@
// Scoreboard for the PS/2 wheel-mouse packet cursor block: predicts packets from accepted bytes.
// Watches the byte, packet and configuration ports, compares every packet and counts mismatches.
// Depends on pmpc_pkg.
module pmpc_packet_checker
  import pmpc_pkg::*;
#(
  parameter int WARMUP_BYTES = WARMUP_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [7:0]            s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [55:0]           m_tdata,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data,
  output int                    mismatches,
  output int                    packets_in_flight,
  output int                    packets_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Mirror of the framer and cursor state.
  logic [7:0]            frame_bytes [4];
  int                    frame_slot;
  bit                    aligned;
  int                    warm_seen;
  logic [COORD_BITS-1:0] col_now;
  logic [COORD_BITS-1:0] row_now;
  logic [COORD_BITS-1:0] screen_w;
  logic [COORD_BITS-1:0] screen_h;

  // Packets predicted but not yet seen on the output.
  result_t pending_packets [$];
  result_t observed;

  // Prints one line per mismatch (the first few dozen) and counts all of them.
  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t ns: MISMATCH %s", $time, msg);
    end
  endtask

  task automatic check_field(input string field, input int got, input int want);
    if (got != want) begin
      report($sformatf("packet %0d %s: got %0d, expected %0d",
                       packets_checked, field, got, want));
    end
  endtask

  // Largest cursor coordinate for a given screen size.
  function automatic int travel_max(input logic [COORD_BITS-1:0] size);
    int lim;
    lim = int'(size) - 5;
    if (lim < 0) lim = 0;
    if (lim > (1 << COORD_BITS) - 1) lim = (1 << COORD_BITS) - 1;
    return lim;
  endfunction

  function automatic logic [COORD_BITS-1:0] pin_to(input int pos, input int lim);
    if (pos < 0) pos = 0;
    if (pos > lim) pos = lim;
    return COORD_BITS'(pos);
  endfunction

  // Stores one received byte, tracks alignment and queues a packet when one completes.
  task automatic take_byte(input logic [7:0] rx);
    int      idx;
    int      nxt;
    bit      done;
    int      dx;
    int      dy;
    result_t pkt;
    idx = frame_slot;
    frame_bytes[idx] = rx;
    nxt = idx + 1;
    // Alignment search once the warm-up is over.
    if (!aligned && warm_seen > WARMUP_BYTES) begin
      if (!rx[3]) begin
        nxt = 0;
      end else if (idx == 0 && !frame_bytes[1][3] && !frame_bytes[2][3]
                   && !frame_bytes[3][3]) begin
        aligned = 1'b1;
      end
    end
    done = 1'b0;
    if (nxt > 3) begin
      nxt = 0;
      done = aligned;
    end
    frame_slot = nxt;
    if (warm_seen <= WARMUP_BYTES) warm_seen++;
    if (done) begin
      dx = int'($signed({frame_bytes[0][4], frame_bytes[1]}));
      dy = int'($signed({frame_bytes[0][5], frame_bytes[2]}));
      col_now = pin_to(int'(col_now) + dx, travel_max(screen_w));
      row_now = pin_to(int'(row_now) - dy, travel_max(screen_h));
      pkt = '0;
      pkt.delta_x       = {frame_bytes[0][4], frame_bytes[1]};
      pkt.delta_y       = {frame_bytes[0][5], frame_bytes[2]};
      pkt.delta_wheel   = frame_bytes[3];
      pkt.left_button   = frame_bytes[0][0];
      pkt.right_button  = frame_bytes[0][1];
      pkt.middle_button = frame_bytes[0][2];
      pkt.cursor_x      = col_now;
      pkt.cursor_y      = row_now;
      pending_packets.push_back(pkt);
    end
  endtask

  task automatic compare_packet(input result_t got, input result_t want);
    check_field("delta_x", int'(got.delta_x), int'(want.delta_x));
    check_field("delta_y", int'(got.delta_y), int'(want.delta_y));
    check_field("delta_wheel", int'(got.delta_wheel), int'(want.delta_wheel));
    check_field("left_button", got.left_button, want.left_button);
    check_field("right_button", got.right_button, want.right_button);
    check_field("middle_button", got.middle_button, want.middle_button);
    check_field("cursor_x", got.cursor_x, want.cursor_x);
    check_field("cursor_y", got.cursor_y, want.cursor_y);
    check_field("padding", got.pad, want.pad);
    packets_checked++;
  endtask

  // Sample all ports at the clock edge; outputs are compared before new bytes are framed.
  always @(posedge clk) begin
    if (rst) begin
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      frame_slot = 0;
      aligned = 1'b0;
      warm_seen = 0;
      col_now = '0;
      row_now = '0;
      screen_w = SCREEN_WIDTH_RST;
      screen_h = SCREEN_HEIGHT_RST;
      pending_packets.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SCREEN_WIDTH) begin
          screen_w = cfg_data;
        end else if (cfg_index == CFG_SCREEN_HEIGHT) begin
          screen_h = cfg_data;
        end
      end
      if (m_tvalid && m_tready) begin
        observed = result_t'(m_tdata);
        if (pending_packets.size() == 0) begin
          report($sformatf("packet output with none outstanding, data %h", m_tdata));
        end else begin
          compare_packet(observed, pending_packets.pop_front());
        end
      end
      if (s_tvalid && s_tready) take_byte(s_tdata);
    end
    packets_in_flight <= pending_packets.size();
  end

endmodule

@@ tb/tb_ps2_wheel_mouse_packet_cursor_top.sv @@
// Testbench top for the PS/2 wheel-mouse packet cursor block: clock, reset, byte stimulus,
// output back-pressure, screen size writes and the final verdict.
// Depends on pmpc_pkg, ps2_wheel_mouse_packet_cursor_top and pmpc_packet_checker.
module tb_ps2_wheel_mouse_packet_cursor_top
  import pmpc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WARMUP         = WARMUP_BYTES_DEF;
  localparam int HOLD_CYCLES    = 64;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [55:0]           m_tdata;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [COORD_BITS-1:0] cfg_data;

  int mismatches;
  int packets_in_flight;
  int packets_checked;
  int bytes_sent = 0;
  int settings_used = 0;
  int quiet_cycles = 0;
  int hold_requests = 0;
  int holds_served = 0;
  bit tx_steady;
  bit rx_steady;

  ps2_wheel_mouse_packet_cursor_top #(.WARMUP_BYTES(WARMUP)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pmpc_packet_checker #(.WARMUP_BYTES(WARMUP)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .packets_in_flight(packets_in_flight),
    .packets_checked(packets_checked)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // Idle length: mostly short, now and then a long one.
  function automatic int pause_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  // Offers one byte, holds it until taken, then maybe idles.
  task automatic send_byte(input logic [7:0] value);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    if (!tx_steady && $urandom_range(0, 3) == 0) begin
      gap = pause_len();
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Mostly whole packets with random content; climbing packets drive the cursor toward
  // the far corner, otherwise a stray byte now and then shifts the framing.
  task automatic run_bytes(input int count, input bit climb);
    int         sent;
    logic [7:0] head;
    logic [7:0] move_x;
    logic [7:0] move_y;
    logic [7:0] wheel;
    sent = 0;
    while (sent < count) begin
      if (!climb && $urandom_range(0, 9) == 0) begin
        send_byte(8'($urandom));
        sent++;
      end else begin
        head   = 8'($urandom);
        head[3] = 1'b1;
        move_x = 8'($urandom);
        move_y = 8'($urandom);
        wheel  = 8'($urandom);
        if (climb) begin
          head[4] = 1'b0;
          head[5] = 1'b1;
          move_x  = 8'($urandom_range(200, 255));
          move_y  = 8'($urandom_range(0, 40));
        end
        send_byte(head);
        send_byte(move_x);
        send_byte(move_y);
        send_byte(wheel);
        sent += 4;
      end
    end
  endtask

  // Stops sending and waits for every predicted packet, plus a drain slack.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (packets_in_flight != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [COORD_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // New screen size and idling style for the next stretch of traffic.
  task automatic start_phase(input logic [COORD_BITS-1:0] width,
                             input logic [COORD_BITS-1:0] height,
                             input bit tx_flat, input bit rx_flat);
    cfg_write(CFG_SCREEN_WIDTH, width);
    cfg_write(CFG_SCREEN_HEIGHT, height);
    tx_steady <= tx_flat;
    rx_steady <= rx_flat;
    settings_used++;
  endtask

  // Output side: random stalls, long hold-offs on request.
  initial begin
    m_tready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat (pause_len()) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // End the run if nothing moves on either stream for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no request accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [7:0] opening [0:28];
    // Warm-up, an unaligned packet end, stale header bits blocking alignment, drops
    // that clear slots 3, 2 and 1 in turn, alignment, then packets at the field extremes.
    opening = '{8'h08, 8'hFF, 8'hFF, 8'hFF, 8'h0F,
                8'h08, 8'h88, 8'hC8,
                8'h38,
                8'h09, 8'h0A, 8'h00,
                8'h28, 8'h0B, 8'h77,
                8'h18, 8'hF7,
                8'h08, 8'h00, 8'h00, 8'h00,
                8'h3F, 8'h00, 8'h00, 8'h80,
                8'hC8, 8'hFF, 8'hFF, 8'h7F};
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= 8'h00;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_data  <= '0;
    tx_steady <= 1'b0;
    rx_steady <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset screen size, idling on both sides.
    settings_used++;
    foreach (opening[i]) send_byte(opening[i]);
    run_bytes(70, 1'b0);
    settle();

    // Largest screen, cursor pushed into the far corner, no idling.
    start_phase(12'd4095, 12'd4095, 1'b1, 1'b1);
    run_bytes(100, 1'b1);
    settle();

    // A 16 by 16 screen: the cursor is pulled back from the far corner.
    start_phase(12'd16, 12'd16, 1'b0, 1'b0);
    run_bytes(60, 1'b0);
    settle();

    // Sizes below five pin the cursor at zero.
    start_phase(12'd4, 12'd0, 1'b1, 1'b0);
    run_bytes(40, 1'b0);
    settle();

    // Sizes of five and six give limits of zero and one.
    start_phase(12'd5, 12'd6, 1'b0, 1'b1);
    run_bytes(40, 1'b0);
    settle();

    // Random mid-range screen.
    start_phase(COORD_BITS'($urandom_range(16, 4095)), COORD_BITS'($urandom_range(16, 4095)),
                1'b0, 1'b0);
    run_bytes(50, 1'b0);
    settle();

    // Back-to-back bytes while the output holds off, so the packet queue fills.
    start_phase(SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST, 1'b1, 1'b1);
    hold_requests <= hold_requests + 1;
    run_bytes(48, 1'b0);
    settle();

    $display("Sent %0d mouse bytes under %0d screen sizes; %0d decoded packets compared.",
             bytes_sent, settings_used, packets_checked);
    $display("Covered warm-up, alignment search, clamping at both limits and a full-queue stall.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/pmpc_pkg.sv
rtl/core/pmpc_front.sv
rtl/core/pmpc_queue.sv
rtl/core/pmpc_back.sv
rtl/core/ps2_wheel_mouse_packet_cursor_top.sv
tb/pmpc_packet_checker.sv
tb/tb_ps2_wheel_mouse_packet_cursor_top.sv
